[rtl/fzc_pkg.sv]
`timescale 1ns / 1ps

package fzc_pkg;

   // register and field widths
   localparam int THR_W       = 11;
   localparam int COUNT_W     = 16;
   localparam int RUN_BITS_W  = 14;
   localparam int OUT_W       = 12;

   // DC tracker scaling: average kept x512, alpha 1/256
   localparam int DC_FRAC     = 9;
   localparam int DC_SHIFT    = 8;

   localparam logic [THR_W-1:0]      THR_RESET    = 11'd100;
   localparam logic [COUNT_W-1:0]    COUNT_MAX    = 16'hFFFF;
   localparam logic [RUN_BITS_W-1:0] RUN_BITS_MAX = 14'd16383;

   // one result item
   typedef struct packed {
      logic                  run_valid;
      logic                  run_bit;
      logic [RUN_BITS_W-1:0] run_bits;
      logic [OUT_W-1:0]      abs_centered;
      logic [OUT_W-1:0]      window_p2p;
   } result_type;

endpackage

[rtl/fzc_ifs.sv]
`timescale 1ns / 1ps

// sample request channel
interface fzc_req_if #(
   parameter int SAMPLE_W = 12
);
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                window_start;

   modport source (output valid, output sample, output window_start, input ready);
   modport sink   (input valid, input sample, input window_start, output ready);
endinterface

// slicer result channel
interface fzc_rsp_if;
   import fzc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  run_valid;
   logic                  run_bit;
   logic [RUN_BITS_W-1:0] run_bits;
   logic [OUT_W-1:0]      abs_centered;
   logic [OUT_W-1:0]      window_p2p;

   modport source (output valid, output run_valid, output run_bit, output run_bits,
                   output abs_centered, output window_p2p, input ready);
   modport sink   (input valid, input run_valid, input run_bit, input run_bits,
                   input abs_centered, input window_p2p, output ready);
endinterface

// hysteresis threshold write channel
interface fzc_csr_if;
   import fzc_pkg::*;
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] hysteresis_threshold;

   modport source (output valid, output hysteresis_threshold, input ready);
   modport sink   (input valid, input hysteresis_threshold, output ready);
endinterface

[rtl/fzc_run_len.sv]
`timescale 1ns / 1ps

// Rounded run length in bits: (count + SPB/2) / SPB, saturated to 14 bits.
// Constant division done as a multiply by a rounded-up reciprocal; with a
// 24-bit shift the quotient is exact for every 17-bit numerator and 2 <= SPB <= 64.
module fzc_run_len #(
   parameter int SAMPLES_PER_BIT = 8
) (
   input  logic [fzc_pkg::COUNT_W-1:0]    count,
   output logic [fzc_pkg::RUN_BITS_W-1:0] run_bits
);
   import fzc_pkg::*;

   localparam int NUM_W   = COUNT_W + 1;
   localparam int RECIP_S = 24;
   localparam int RECIP_W = RECIP_S;
   localparam longint RECIP = ((64'd1 << RECIP_S) + SAMPLES_PER_BIT - 1) / SAMPLES_PER_BIT;
   localparam logic [NUM_W-1:0] HALF = NUM_W'(SAMPLES_PER_BIT / 2);

   logic [NUM_W-1:0]         numer;
   logic [NUM_W+RECIP_W-1:0] product;
   logic [NUM_W-1:0]         quot;

   assign numer   = {1'b0, count} + HALF;
   assign product = {{RECIP_W{1'b0}}, numer} * {{NUM_W{1'b0}}, RECIP_W'(RECIP)};
   assign quot    = product[NUM_W+RECIP_W-1:RECIP_S];

   // saturate to the field width
   assign run_bits = (quot > NUM_W'(RUN_BITS_MAX)) ? RUN_BITS_MAX : quot[RUN_BITS_W-1:0];

endmodule

[rtl/fzc_slicer_core.sv]
`timescale 1ns / 1ps

// DC tracker, two-tap smoother, hysteresis slicer, run counter and window
// min/max. State advances on step; the result is combinational from the
// registered sample.
module fzc_slicer_core #(
   parameter int SAMPLES_PER_BIT = 8,
   parameter int SAMPLE_BITS     = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [SAMPLE_BITS-1:0]      sample,
   input  logic                        window_start,
   input  logic [fzc_pkg::THR_W-1:0]   threshold,
   output fzc_pkg::result_type         result
);
   import fzc_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int DW    = SB + DC_FRAC;
   localparam int SUM_W = DW + DC_SHIFT + 1;
   localparam int CMP_W = (SB + 2 > THR_W + 2) ? SB + 2 : THR_W + 2;
   localparam int XW    = (SB > OUT_W) ? SB : OUT_W;

   logic [DW-1:0]          dc_avg_ff, dc_avg_in;
   logic signed [SB:0]     prev_ff, prev_in;
   logic                   pos_ff, pos_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [SB-1:0]          wmin_ff, wmin_in;
   logic [SB-1:0]          wmax_ff, wmax_in;

   logic [SB-1:0]          wmin_base, wmax_base;
   logic [DW-1:0]          dc_seed, sample_scaled;
   logic [SUM_W-1:0]       dc_sum;
   logic [SB-1:0]          dc_level;
   logic signed [SB:0]     centered;
   logic [SB:0]            mag;
   logic [XW-1:0]          mag_x;
   logic signed [SB+1:0]   pair_sum;
   logic signed [SB+1:0]   filtered;
   logic signed [CMP_W-1:0] filt_c, thr_c;
   logic                   pos_base, new_pos, change;
   logic [COUNT_W-1:0]     count_base, count_after;
   logic [RUN_BITS_W-1:0]  len;
   logic [SB-1:0]          p2p;
   logic [XW-1:0]          p2p_x;

   // window min/max, restarted by window start
   always_comb begin
      wmin_base = window_start ? {SB{1'b1}} : wmin_ff;
      wmax_base = window_start ? {SB{1'b0}} : wmax_ff;
      wmin_in   = (sample < wmin_base) ? sample : wmin_base;
      wmax_in   = (sample > wmax_base) ? sample : wmax_base;
      p2p       = (wmax_in > wmin_in) ? (wmax_in - wmin_in) : {SB{1'b0}};
      p2p_x     = XW'(p2p);
   end

   // DC average: seed when zero, then dc = (dc*255 + s*512) / 256
   always_comb begin
      sample_scaled = {sample, {DC_FRAC{1'b0}}};
      dc_seed       = (dc_avg_ff == '0) ? sample_scaled : dc_avg_ff;
      dc_sum        = {1'b0, dc_seed, {DC_SHIFT{1'b0}}} - SUM_W'(dc_seed) + SUM_W'(sample_scaled);
      dc_avg_in     = dc_sum[DW+DC_SHIFT-1:DC_SHIFT];
      dc_level      = dc_avg_in[DW-1:DC_FRAC];
   end

   // centering and magnitude
   always_comb begin
      centered = $signed({1'b0, sample}) - $signed({1'b0, dc_level});
      mag      = centered[SB] ? (~centered + 1'b1) : centered;
      mag_x    = XW'(mag[SB-1:0]);
      prev_in  = centered;
   end

   // two-tap average, floor rounding, then hysteresis slicer
   always_comb begin
      pair_sum = $signed({centered[SB], centered}) + $signed({prev_ff[SB], prev_ff});
      filtered = pair_sum >>> 1;
      filt_c   = CMP_W'(filtered);
      thr_c    = $signed({{(CMP_W-THR_W){1'b0}}, threshold});
      pos_base = window_start ? 1'b1 : pos_ff;
      if (filt_c > thr_c) begin
         new_pos = 1'b1;
      end else if (filt_c < -thr_c) begin
         new_pos = 1'b0;
      end else begin
         new_pos = pos_base;
      end
      change = new_pos != pos_base;
      pos_in = new_pos;
   end

   // run counter, restarts at one after a change, saturating
   always_comb begin
      count_base  = window_start ? '0 : count_ff;
      count_after = change ? '0 : count_base;
      count_in    = (count_after != COUNT_MAX) ? count_after + 1'b1 : count_after;
   end

   fzc_run_len #(
      .SAMPLES_PER_BIT (SAMPLES_PER_BIT)
   ) u_run_len (
      .count    (count_base),
      .run_bits (len)
   );

   // result assembly
   always_comb begin
      result.run_valid    = change;
      result.run_bit      = change & pos_base;
      result.run_bits     = change ? len : '0;
      result.abs_centered = mag_x[OUT_W-1:0];
      result.window_p2p   = p2p_x[OUT_W-1:0];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dc_avg_ff <= '0;
         prev_ff   <= '0;
         pos_ff    <= 1'b1;
         count_ff  <= '0;
         wmin_ff   <= {SB{1'b1}};
         wmax_ff   <= '0;
      end else if (step) begin
         dc_avg_ff <= dc_avg_in;
         prev_ff   <= prev_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         wmin_ff   <= wmin_in;
         wmax_ff   <= wmax_in;
      end
   end

endmodule

[rtl/fsk_zero_crossing_bit_slicer_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Handshake
// req       in   sample, window_start                                 valid/ready
// rsp       out  run_valid, run_bit, run_bits, abs_centered, window_p2p valid/ready
// csr       in   hysteresis_threshold                                 valid/ready
//
// One sample per clock sustained while rsp is ready; a request passes the input
// register, then the result register, before its result is valid.
// The rate is set by the single pass through the core between those two
// registers; all per-sample state updates in that same cycle.
// Synchronous active-high reset; threshold resets to 100, csr is always ready.
// A stalled rsp holds the result and the input register; req stays ready
// while the input register is empty or moving on.
module fsk_zero_crossing_bit_slicer_unit #(
   parameter int SAMPLES_PER_BIT = 8,
   parameter int SAMPLE_BITS     = 12
) (
   input  logic     clock,
   input  logic     reset,
   fzc_req_if.sink  req,
   fzc_rsp_if.source rsp,
   fzc_csr_if.sink  csr
);
   import fzc_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic                   in_wstart_ff;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_data_ff;
   result_type             core_result;
   logic [THR_W-1:0]       thr_ff;
   logic                   advance, step, req_fire;

   // pipeline control
   assign advance   = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      out_valid_in = step ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr.valid) begin
         thr_ff <= csr.hysteresis_threshold;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_sample_ff <= req.sample;
         in_wstart_ff <= req.window_start;
      end
   end

   fzc_slicer_core #(
      .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .sample       (in_sample_ff),
      .window_start (in_wstart_ff),
      .threshold    (thr_ff),
      .result       (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.run_valid    = out_data_ff.run_valid;
   assign rsp.run_bit      = out_data_ff.run_bit;
   assign rsp.run_bits     = out_data_ff.run_bits;
   assign rsp.abs_centered = out_data_ff.abs_centered;
   assign rsp.window_p2p   = out_data_ff.window_p2p;

`ifndef ASSERT_OFF
   // a processed request always shows up as a result next cycle
   a_step_to_result: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed request did not reach result register");

   // a new request never overwrites a held, unprocessed request
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_fire && in_valid_ff) |-> step)
      else $error("input register overwritten");

   // run fields are zero when no run ended
   a_run_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.run_valid) |->
         (!out_data_ff.run_bit && (out_data_ff.run_bits == '0)))
      else $error("run fields set without a run");
`endif

endmodule
